>>> rtl/core/tdc_readout_packet_parser_defines.svh
// Assertion macros shared by the readout parser RTL
`ifndef TDC_READOUT_PACKET_PARSER_DEFINES_SVH
`define TDC_READOUT_PACKET_PARSER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define TDCRP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication
`define TDCRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TDCRP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define TDCRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> rtl/core/tdcrp_pkg.sv
`default_nettype none
package tdcrp_pkg;

	// bank limits
	localparam int MAX_BANK_WORDS = 65536;
	localparam int IDX_W          = $clog2(MAX_BANK_WORDS + 1);
	localparam int HDR_WORDS      = 7;

	// result queue sizing
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	// word patterns
	localparam logic [31:0] TRAILER_WORD  = 32'h0001_5555;
	localparam logic [31:0] TYPE_MASK     = 32'he000_0000;
	localparam logic [31:0] EPOCH_CODE    = 32'h6000_0000;
	localparam logic [31:0] TDC_CODE      = 32'h8000_0000;
	localparam logic [31:0] LOW_MASK      = 32'h0000_ffff;
	localparam logic [31:0] BLD_FPGA_MASK = 32'hfff0_ffff;
	localparam logic [31:0] FPGA_ID_MIN   = 32'h0000_0100;
	localparam logic [31:0] FPGA_ID_MAX   = 32'h0000_0103;

	// register and result codes
	localparam logic       MODE_DIRECT  = 1'b0;
	localparam logic       MODE_BUILDER = 1'b1;
	localparam logic       KIND_MEAS    = 1'b0;
	localparam logic       KIND_SUM     = 1'b1;
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_MISMATCH  = 2'd1;
	localparam logic [1:0] ST_SHORT     = 2'd2;

	typedef enum logic [2:0] {
		PH_PRE, PH_FPGA, PH_HDR, PH_BODY, PH_TDC, PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		TRL_NONE, TRL_OK, TRL_BAD
	} trailer_t;

	typedef struct packed {
		logic        result_kind;
		logic [31:0] fpga_word;
		logic [31:0] header_word;
		logic [31:0] epoch_word;
		logic [31:0] tdc_word;
		logic [31:0] decoding_word;
		logic [31:0] sequence_number;
		logic [31:0] run_number;
		logic [31:0] date_value;
		logic [31:0] time_value;
		logic [1:0]  bank_status;
		logic        last_of_run;
	} rec_t;

	// up to two records pushed per processed word, rec0 first
	typedef struct packed {
		logic [1:0] count;
		rec_t       rec0;
		rec_t       rec1;
	} push_t;

	function automatic logic [31:0] swap32(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

	function automatic logic is_epoch(input logic [31:0] x);
		return (x & TYPE_MASK) == EPOCH_CODE;
	endfunction

	function automatic logic is_tdc(input logic [31:0] x);
		return (x & TYPE_MASK) == TDC_CODE;
	endfunction

endpackage
`default_nettype wire

>>> rtl/core/tdcrp_ifs.sv
`default_nettype none
// Word channel into the parser
interface tdcrp_word_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_word;
	logic        bank_start;
	logic        bank_end;

	modport source (output valid, data_word, bank_start, bank_end, input ready);
	modport sink   (input valid, data_word, bank_start, bank_end, output ready);
endinterface

// Result channel out of the parser
interface tdcrp_result_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [31:0] fpga_word;
	logic [31:0] header_word;
	logic [31:0] epoch_word;
	logic [31:0] tdc_word;
	logic [31:0] decoding_word;
	logic [31:0] sequence_number;
	logic [31:0] run_number;
	logic [31:0] date_value;
	logic [31:0] time_value;
	logic [1:0]  bank_status;
	logic        last_of_run;

	modport source (output valid, result_kind, fpga_word, header_word, epoch_word, tdc_word,
		decoding_word, sequence_number, run_number, date_value, time_value, bank_status,
		last_of_run, input ready);
	modport sink   (input valid, result_kind, fpga_word, header_word, epoch_word, tdc_word,
		decoding_word, sequence_number, run_number, date_value, time_value, bank_status,
		last_of_run, output ready);
endinterface
`default_nettype wire

>>> rtl/core/tdcrp_parse_core.sv
`default_nettype none
`include "tdc_readout_packet_parser_defines.svh"
module tdcrp_parse_core (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              format_mode,
	tdcrp_word_if.sink       words,
	input  wire              room,
	output tdcrp_pkg::push_t push
);

	// input register
	logic        valid_s1;
	logic [31:0] word_s1;
	logic        start_s1;
	logic        end_s1;

	// bank state
	logic [tdcrp_pkg::IDX_W-1:0] idx_q;
	logic                        swap_q;
	logic [31:0]                 raw_size_q;
	logic [29:0]                 sub_q;
	tdcrp_pkg::phase_t           phase_q;
	logic [15:0]                 rem_q;
	logic [31:0]                 fpga_q;
	logic [31:0]                 tdh_q;
	logic [31:0]                 epoch_q;
	logic [31:0]                 hw_q [tdcrp_pkg::HDR_WORDS];
	tdcrp_pkg::trailer_t         trl_q;

	// next state before the end-of-bank clear
	logic [tdcrp_pkg::IDX_W-1:0] idx_n;
	logic                        swap_n;
	logic [31:0]                 raw_size_n;
	logic [29:0]                 sub_n;
	tdcrp_pkg::phase_t           phase_n;
	logic [15:0]                 rem_n;
	logic [31:0]                 fpga_n;
	logic [31:0]                 tdh_n;
	logic [31:0]                 epoch_n;
	logic [31:0]                 hw_n [tdcrp_pkg::HDR_WORDS];
	tdcrp_pkg::trailer_t         trl_n;
	logic                        meas_vld;
	logic [31:0]                 meas_tdc;

	logic consume;
	assign consume     = valid_s1 && room;
	assign words.ready = !valid_s1 || consume;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (words.valid && words.ready) begin
			valid_s1 <= 1'b1;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (words.valid && words.ready) begin
			word_s1  <= words.data_word;
			start_s1 <= words.bank_start;
			end_s1   <= words.bank_end;
		end
	end

	// word decode and state update
	always_comb begin
		logic [31:0] v;
		logic [31:0] sz;
		logic [31:0] hv;
		logic [31:0] msk;
		if (start_s1) begin
			idx_n      = '0;
			swap_n     = 1'b0;
			raw_size_n = '0;
			sub_n      = '0;
			phase_n    = tdcrp_pkg::PH_PRE;
			rem_n      = '0;
			fpga_n     = '0;
			tdh_n      = '0;
			epoch_n    = '0;
			for (int i = 0; i < tdcrp_pkg::HDR_WORDS; i++) hw_n[i] = '0;
			trl_n      = tdcrp_pkg::TRL_NONE;
		end else begin
			idx_n      = idx_q;
			swap_n     = swap_q;
			raw_size_n = raw_size_q;
			sub_n      = sub_q;
			phase_n    = phase_q;
			rem_n      = rem_q;
			fpga_n     = fpga_q;
			tdh_n      = tdh_q;
			epoch_n    = epoch_q;
			for (int i = 0; i < tdcrp_pkg::HDR_WORDS; i++) hw_n[i] = hw_q[i];
			trl_n      = trl_q;
		end
		meas_vld = 1'b0;
		meas_tdc = '0;
		v        = '0;
		sz       = '0;
		hv       = '0;
		msk      = '0;
		if (idx_n < tdcrp_pkg::IDX_W'(tdcrp_pkg::MAX_BANK_WORDS)) begin
			for (int i = 0; i < tdcrp_pkg::HDR_WORDS; i++) begin
				if (idx_n == tdcrp_pkg::IDX_W'(i)) hw_n[i] = word_s1;
			end
			if (idx_n == tdcrp_pkg::IDX_W'(2)) raw_size_n = word_s1;
			if (format_mode == tdcrp_pkg::MODE_BUILDER) begin
				// builder format: header words, then a free scan
				if (idx_n >= tdcrp_pkg::IDX_W'(tdcrp_pkg::HDR_WORDS)) begin
					if (phase_n == tdcrp_pkg::PH_PRE) phase_n = tdcrp_pkg::PH_FPGA;
					if (phase_n == tdcrp_pkg::PH_HDR) begin
						tdh_n   = word_s1;
						phase_n = tdcrp_pkg::PH_FPGA;
					end else if (phase_n == tdcrp_pkg::PH_TDC) begin
						if (tdcrp_pkg::is_tdc(word_s1)) begin
							meas_vld = 1'b1;
							meas_tdc = word_s1;
						end
						phase_n = tdcrp_pkg::PH_FPGA;
					end else begin
						phase_n = tdcrp_pkg::PH_FPGA;
						msk     = word_s1 & tdcrp_pkg::BLD_FPGA_MASK;
						if (msk >= tdcrp_pkg::FPGA_ID_MIN && msk <= tdcrp_pkg::FPGA_ID_MAX) begin
							fpga_n  = word_s1;
							phase_n = tdcrp_pkg::PH_HDR;
						end else if (tdcrp_pkg::is_epoch(word_s1)) begin
							epoch_n = word_s1;
							phase_n = tdcrp_pkg::PH_TDC;
						end
					end
				end
			end else begin
				// direct format: endian check on word 3, size taken from word 2
				if (idx_n == tdcrp_pkg::IDX_W'(3)) begin
					swap_n = !(word_s1[0] && !word_s1[31]);
					sz     = swap_n ? tdcrp_pkg::swap32(raw_size_n) : raw_size_n;
					sub_n  = sz[31:2];
					if (sub_n <= 30'd3) begin
						case (sub_n[1:0])
							2'd0:    hv = hw_n[0];
							2'd1:    hv = hw_n[1];
							2'd2:    hv = hw_n[2];
							default: hv = hw_n[3];
						endcase
						hv = swap_n ? tdcrp_pkg::swap32(hv) : hv;
						if (trl_n == tdcrp_pkg::TRL_NONE) begin
							trl_n = (hv == tdcrp_pkg::TRAILER_WORD) ?
								tdcrp_pkg::TRL_OK : tdcrp_pkg::TRL_BAD;
						end
					end
				end
				v = swap_n ? tdcrp_pkg::swap32(word_s1) : word_s1;
				// trailer at the size index
				if (idx_n > tdcrp_pkg::IDX_W'(3) && 32'(idx_n) == {2'b00, sub_n}) begin
					if (trl_n == tdcrp_pkg::TRL_NONE) begin
						trl_n = (v == tdcrp_pkg::TRAILER_WORD) ?
							tdcrp_pkg::TRL_OK : tdcrp_pkg::TRL_BAD;
					end
				end
				// section walk
				if (idx_n >= tdcrp_pkg::IDX_W'(6)) begin
					if (phase_n == tdcrp_pkg::PH_PRE) phase_n = tdcrp_pkg::PH_FPGA;
					case (phase_n)
						tdcrp_pkg::PH_FPGA: begin
							msk = v & tdcrp_pkg::LOW_MASK;
							if (msk >= tdcrp_pkg::FPGA_ID_MIN && msk <= tdcrp_pkg::FPGA_ID_MAX) begin
								fpga_n  = v;
								rem_n   = v[31:16];
								phase_n = tdcrp_pkg::PH_HDR;
							end else begin
								phase_n = tdcrp_pkg::PH_DONE;
							end
						end
						tdcrp_pkg::PH_HDR: begin
							tdh_n   = v;
							phase_n = (rem_n != 16'd0) ? tdcrp_pkg::PH_BODY : tdcrp_pkg::PH_FPGA;
						end
						tdcrp_pkg::PH_BODY: begin
							if (rem_n != 16'd0) rem_n = rem_n - 16'd1;
							if (tdcrp_pkg::is_epoch(v)) begin
								epoch_n = v;
								if (rem_n != 16'd0) rem_n = rem_n - 16'd1;
								phase_n = tdcrp_pkg::PH_TDC;
							end else if (rem_n == 16'd0) begin
								phase_n = tdcrp_pkg::PH_FPGA;
							end
						end
						tdcrp_pkg::PH_TDC: begin
							if (tdcrp_pkg::is_tdc(v)) begin
								meas_vld = 1'b1;
								meas_tdc = v;
							end
							phase_n = (rem_n != 16'd0) ? tdcrp_pkg::PH_BODY : tdcrp_pkg::PH_FPGA;
						end
						default: begin
						end
					endcase
				end
			end
			idx_n = idx_n + tdcrp_pkg::IDX_W'(1);
		end
	end

	// result records
	always_comb begin
		tdcrp_pkg::rec_t base;
		tdcrp_pkg::rec_t meas;
		tdcrp_pkg::rec_t summ;
		base = '0;
		if (format_mode == tdcrp_pkg::MODE_BUILDER) begin
			base.decoding_word   = hw_n[1];
			base.sequence_number = hw_n[3];
			base.run_number      = hw_n[4];
			base.date_value      = hw_n[5];
			base.time_value      = hw_n[6];
		end else begin
			base.decoding_word   = swap_n ? tdcrp_pkg::swap32(hw_n[3]) : hw_n[3];
		end
		meas             = base;
		meas.result_kind = tdcrp_pkg::KIND_MEAS;
		meas.fpga_word   = fpga_n;
		meas.header_word = tdh_n;
		meas.epoch_word  = epoch_n;
		meas.tdc_word    = meas_tdc;
		meas.last_of_run = !end_s1;
		summ             = base;
		summ.result_kind = tdcrp_pkg::KIND_SUM;
		summ.last_of_run = 1'b1;
		if (format_mode == tdcrp_pkg::MODE_BUILDER) begin
			summ.fpga_word   = hw_n[0];
			summ.header_word = hw_n[2];
		end else begin
			case (trl_n)
				tdcrp_pkg::TRL_OK:  summ.bank_status = tdcrp_pkg::ST_OK;
				tdcrp_pkg::TRL_BAD: summ.bank_status = tdcrp_pkg::ST_MISMATCH;
				default:            summ.bank_status = tdcrp_pkg::ST_SHORT;
			endcase
		end
		push.count = consume ? ({1'b0, meas_vld} + {1'b0, end_s1}) : 2'd0;
		push.rec0  = meas_vld ? meas : summ;
		push.rec1  = summ;
	end

	// bank state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			swap_q     <= 1'b0;
			raw_size_q <= '0;
			sub_q      <= '0;
			phase_q    <= tdcrp_pkg::PH_PRE;
			rem_q      <= '0;
			fpga_q     <= '0;
			tdh_q      <= '0;
			epoch_q    <= '0;
			for (int i = 0; i < tdcrp_pkg::HDR_WORDS; i++) hw_q[i] <= '0;
			trl_q      <= tdcrp_pkg::TRL_NONE;
		end else if (consume) begin
			if (end_s1) begin
				idx_q      <= '0;
				swap_q     <= 1'b0;
				raw_size_q <= '0;
				sub_q      <= '0;
				phase_q    <= tdcrp_pkg::PH_PRE;
				rem_q      <= '0;
				fpga_q     <= '0;
				tdh_q      <= '0;
				epoch_q    <= '0;
				for (int i = 0; i < tdcrp_pkg::HDR_WORDS; i++) hw_q[i] <= '0;
				trl_q      <= tdcrp_pkg::TRL_NONE;
			end else begin
				idx_q      <= idx_n;
				swap_q     <= swap_n;
				raw_size_q <= raw_size_n;
				sub_q      <= sub_n;
				phase_q    <= phase_n;
				rem_q      <= rem_n;
				fpga_q     <= fpga_n;
				tdh_q      <= tdh_n;
				epoch_q    <= epoch_n;
				for (int i = 0; i < tdcrp_pkg::HDR_WORDS; i++) hw_q[i] <= hw_n[i];
				trl_q      <= trl_n;
			end
		end
	end

	// checks
	`TDCRP_ASSERT_NEXT(a_clear_after_end, clk, arst_n,
		consume && end_s1, idx_q == '0,
		"bank state not cleared after bank end")
	`TDCRP_ASSERT_IMPL(a_meas_from_tdc, clk, arst_n,
		push.count != 2'd0 && push.rec0.result_kind == tdcrp_pkg::KIND_MEAS,
		!start_s1 && phase_q == tdcrp_pkg::PH_TDC,
		"measurement outside TDC phase")
	`TDCRP_ASSERT_IMPL(a_ready_when_empty, clk, arst_n,
		!valid_s1, words.ready,
		"word channel not ready with the input register empty")

endmodule
`default_nettype wire

>>> rtl/core/tdcrp_result_fifo.sv
`default_nettype none
`include "tdc_readout_packet_parser_defines.svh"
module tdcrp_result_fifo (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire tdcrp_pkg::push_t push,
	output logic                  room,
	tdcrp_result_if.source        results
);

	tdcrp_pkg::rec_t                  mem [tdcrp_pkg::FIFO_DEPTH];
	logic [tdcrp_pkg::FIFO_PTR_W-1:0] wr_ptr_q;
	logic [tdcrp_pkg::FIFO_PTR_W-1:0] rd_ptr_q;
	logic [tdcrp_pkg::FIFO_CNT_W-1:0] cnt_q;
	logic                             pop;
	tdcrp_pkg::rec_t                  head;

	// space for a full two-record push
	assign room = cnt_q <= tdcrp_pkg::FIFO_CNT_W'(tdcrp_pkg::FIFO_DEPTH - 2);
	assign pop  = results.valid && results.ready;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + tdcrp_pkg::FIFO_PTR_W'(push.count);
			rd_ptr_q <= rd_ptr_q + tdcrp_pkg::FIFO_PTR_W'(pop);
			cnt_q    <= cnt_q + tdcrp_pkg::FIFO_CNT_W'(push.count)
				- tdcrp_pkg::FIFO_CNT_W'(pop);
		end
	end

	// record storage
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) mem[wr_ptr_q] <= push.rec0;
		if (push.count == 2'd2) mem[wr_ptr_q + tdcrp_pkg::FIFO_PTR_W'(1)] <= push.rec1;
	end

	// head of queue drives the channel
	assign head                    = mem[rd_ptr_q];
	assign results.valid           = cnt_q != '0;
	assign results.result_kind     = head.result_kind;
	assign results.fpga_word       = head.fpga_word;
	assign results.header_word     = head.header_word;
	assign results.epoch_word      = head.epoch_word;
	assign results.tdc_word        = head.tdc_word;
	assign results.decoding_word   = head.decoding_word;
	assign results.sequence_number = head.sequence_number;
	assign results.run_number      = head.run_number;
	assign results.date_value      = head.date_value;
	assign results.time_value      = head.time_value;
	assign results.bank_status     = head.bank_status;
	assign results.last_of_run     = head.last_of_run;

	// checks
	`TDCRP_ASSERT_IMPL(a_no_overflow, clk, arst_n,
		1'b1, cnt_q <= tdcrp_pkg::FIFO_CNT_W'(tdcrp_pkg::FIFO_DEPTH),
		"result queue overflow")
	`TDCRP_ASSERT_IMPL(a_push_needs_room, clk, arst_n,
		push.count != 2'd0, room,
		"push without room")
	`TDCRP_ASSERT_IMPL(a_summary_last, clk, arst_n,
		results.valid && results.result_kind == tdcrp_pkg::KIND_SUM, results.last_of_run,
		"summary not flagged last")

endmodule
`default_nettype wire

>>> rtl/core/tdc_readout_packet_parser.sv
// Channel   Dir  Handshake     Payload
// words     in   valid/ready   data_word, bank_start, bank_end
// results   out  valid/ready   one record: kind, section words, header words, status
// cfg       in   cfg_wr_en     cfg_wr_data -> format_mode
//
// One word per cycle while the result queue has room: a word is held in the
// input register, then its records are written to a four-entry result queue.
// A word gives at most two records, so one with both a measurement and a summary
// takes two queue entries; the output side sends one per cycle while ready is high.
// The input stalls only when the queue has fewer than two free entries.
// Reset clears the bank state, the queue and format_mode (direct format).
`default_nettype none
module tdc_readout_packet_parser (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            cfg_wr_en,
	input  wire            cfg_wr_data,
	tdcrp_word_if.sink     words,
	tdcrp_result_if.source results
);

	logic             format_mode_q;
	logic             room;
	tdcrp_pkg::push_t push;

	// format register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			format_mode_q <= tdcrp_pkg::MODE_DIRECT;
		end else if (cfg_wr_en) begin
			format_mode_q <= cfg_wr_data;
		end
	end

	tdcrp_parse_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.format_mode (format_mode_q),
		.words       (words),
		.room        (room),
		.push        (push)
	);

	tdcrp_result_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.room    (room),
		.results (results)
	);

endmodule
`default_nettype wire
